// ----- rtl/chm_pkg.sv -----
// shared types, constants and codes for the chained hash map engine
package chm_pkg;

  localparam int NUM_BUCKETS  = 64;
  localparam int POOL_ENTRIES = 64;
  localparam int BKT_W        = $clog2(NUM_BUCKETS);
  localparam int IDX_W        = $clog2(POOL_ENTRIES);
  localparam int PTR_W        = IDX_W + 1;
  localparam int CNT_W        = 7;
  localparam int CFG_W        = 7;
  localparam int DIV_BITS     = 4;
  localparam int DIV_STEPS    = 64 / DIV_BITS;
  localparam int DCNT_W       = $clog2(DIV_STEPS);

  localparam logic [PTR_W-1:0] NIL      = PTR_W'(POOL_ENTRIES);
  localparam logic [25:0]      HASH_MUL = 26'd62342347;
  localparam logic [63:0]      ALL_ONES = '1;

  localparam logic [1:0] FN_ADD    = 2'd0;
  localparam logic [1:0] FN_REMOVE = 2'd1;
  localparam logic [1:0] FN_CHANGE = 2'd2;
  localparam logic [1:0] FN_LOOKUP = 2'd3;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic [1:0]  func;
    logic [63:0] key;
    logic [63:0] value_in;
  } req_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [CNT_W-1:0] entry_count;
    logic [63:0]      value_out;
  } rsp_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic mul_lo;
    logic mul_hi;
    logic sum;
    logic div_step;
    logic head_rd;
    logic setup;
    logic node_rd;
    logic node_cmp;
    logic apply;
    logic link;
    logic emit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic walk_end;
    logic match;
    logic need_link;
    logic out_free;
  } sts_t;

endpackage

// ----- rtl/chm_ctrl.sv -----
// controller state machine: sequences hash, modulo, chain walk and update
module chm_ctrl import chm_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [11:0] {
    S_IDLE  = 12'b000000000001,
    S_MLO   = 12'b000000000010,
    S_MHI   = 12'b000000000100,
    S_SUM   = 12'b000000001000,
    S_DIV   = 12'b000000010000,
    S_HRD   = 12'b000000100000,
    S_SETUP = 12'b000001000000,
    S_NRD   = 12'b000010000000,
    S_NCMP  = 12'b000100000000,
    S_APPLY = 12'b001000000000,
    S_LINK  = 12'b010000000000,
    S_DONE  = 12'b100000000000
  } state_t;

  state_t state, state_next;
  logic [DCNT_W-1:0] dcnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      dcnt  <= '0;
    end else begin
      state <= state_next;
      if (state == S_DIV) dcnt <= dcnt + DCNT_W'(1);
      else dcnt <= '0;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    req_ready = 1'b0;
    unique case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        cmd.load = req_valid;
        if (req_valid) state_next = S_MLO;
      end
      S_MLO: begin
        cmd.mul_lo = 1'b1;
        state_next = S_MHI;
      end
      S_MHI: begin
        cmd.mul_hi = 1'b1;
        state_next = S_SUM;
      end
      S_SUM: begin
        cmd.sum = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (dcnt == DCNT_W'(DIV_STEPS - 1)) state_next = S_HRD;
      end
      S_HRD: begin
        cmd.head_rd = 1'b1;
        state_next = S_SETUP;
      end
      S_SETUP: begin
        cmd.setup = 1'b1;
        state_next = S_NRD;
      end
      S_NRD: begin
        if (sts.walk_end) begin
          state_next = S_APPLY;
        end else begin
          cmd.node_rd = 1'b1;
          state_next = S_NCMP;
        end
      end
      S_NCMP: begin
        cmd.node_cmp = 1'b1;
        state_next = sts.match ? S_APPLY : S_NRD;
      end
      S_APPLY: begin
        cmd.apply = 1'b1;
        state_next = sts.need_link ? S_LINK : S_DONE;
      end
      S_LINK: begin
        cmd.link = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        cmd.emit = sts.out_free;
        if (sts.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ----- rtl/chm_dp.sv -----
// datapath: hash multiplier, modulo unit, bucket and node memories, result register
module chm_dp import chm_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  cmd_t             cmd,
  output sts_t             sts,
  input  req_t             req,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_data,
  output logic             rsp_valid,
  input  logic             rsp_ready,
  output rsp_t             rsp
);

  logic [CFG_W-1:0] bucket_count;
  logic [CFG_W-1:0] m_eff;

  logic [1:0]  func_r;
  logic [63:0] key_r;
  logic [63:0] val_r;

  logic [31:0] mul_a;
  logic [57:0] prod;
  logic [57:0] p_lo;
  logic [31:0] p_hi;
  logic [63:0] h;
  logic [BKT_W-1:0] rem, rem_next;

  logic [BKT_W-1:0] head_mem [NUM_BUCKETS];
  logic [NUM_BUCKETS-1:0] head_vld;
  logic [BKT_W-1:0] head_q;
  logic             head_v_q;

  logic [63:0]      key_mem  [POOL_ENTRIES];
  logic [63:0]      val_mem  [POOL_ENTRIES];
  logic [PTR_W-1:0] next_mem [POOL_ENTRIES];
  logic [63:0]      key_q;
  logic [63:0]      val_q;
  logic [PTR_W-1:0] next_q;

  logic [POOL_ENTRIES-1:0] in_use;
  logic [PTR_W-1:0] cur, prev;
  logic [PTR_W-1:0] steps;
  logic             found;
  logic [IDX_W-1:0] fr_q;
  logic             full_q;
  logic [IDX_W-1:0] fr;
  logic             full;
  logic [CNT_W-1:0] count;

  logic [1:0]  res_status;
  logic [63:0] res_vout;
  logic        new_node;
  logic        change_wr;

  // lowest free node of the pool
  always_comb begin
    fr = '0;
    full = 1'b1;
    for (int i = POOL_ENTRIES - 1; i >= 0; i--) begin
      if (!in_use[i]) begin
        fr = IDX_W'(i);
        full = 1'b0;
      end
    end
  end

  always_comb begin
    if (bucket_count == '0) m_eff = CFG_W'(1);
    else if (bucket_count > CFG_W'(NUM_BUCKETS)) m_eff = CFG_W'(NUM_BUCKETS);
    else m_eff = bucket_count;
  end

  assign mul_a = cmd.mul_hi ? key_r[63:32] : key_r[31:0];
  assign prod  = mul_a * HASH_MUL;

  // restoring remainder, several dividend bits per cycle
  always_comb begin
    logic [BKT_W:0] t;
    rem_next = rem;
    for (int i = 0; i < DIV_BITS; i++) begin
      t = {rem_next, h[63 - i]};
      if (t >= m_eff) t = t - m_eff;
      rem_next = t[BKT_W-1:0];
    end
  end

  assign new_node  = (func_r == FN_ADD) && !found && !full_q;
  assign change_wr = (func_r == FN_CHANGE) && (val_r != ALL_ONES);

  assign sts.walk_end  = cur[IDX_W] || (steps == PTR_W'(POOL_ENTRIES));
  assign sts.match     = (key_q == key_r);
  assign sts.need_link = new_node && !prev[IDX_W];
  assign sts.out_free  = !rsp_valid || rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      bucket_count <= CFG_W'(NUM_BUCKETS);
      head_vld     <= '0;
      in_use       <= '0;
      count        <= '0;
      rsp_valid    <= 1'b0;
    end else begin
      if (cfg_we) bucket_count <= cfg_data;
      if (cmd.apply) begin
        if (new_node) begin
          in_use[fr_q] <= 1'b1;
          count <= count + CNT_W'(1);
          if (prev[IDX_W]) head_vld[rem] <= 1'b1;
        end else if (func_r == FN_REMOVE && found) begin
          in_use[cur[IDX_W-1:0]] <= 1'b0;
          if (count != '0) count <= count - CNT_W'(1);
          if (prev[IDX_W]) head_vld[rem] <= !next_q[IDX_W];
        end
      end
      if (cmd.emit) rsp_valid <= 1'b1;
      else if (rsp_ready) rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r <= req.func;
      key_r  <= req.key;
      val_r  <= req.value_in;
    end
    if (cmd.mul_lo) p_lo <= prod;
    if (cmd.mul_hi) p_hi <= prod[31:0];
    if (cmd.sum) begin
      h   <= {6'b0, p_lo} + {p_hi, 32'b0};
      rem <= '0;
    end
    if (cmd.div_step) begin
      h   <= h << DIV_BITS;
      rem <= rem_next;
    end
    if (cmd.head_rd) begin
      head_q   <= head_mem[rem];
      head_v_q <= head_vld[rem];
    end
    if (cmd.setup) begin
      cur    <= head_v_q ? {1'b0, head_q} : NIL;
      prev   <= NIL;
      steps  <= '0;
      found  <= 1'b0;
      fr_q   <= fr;
      full_q <= full;
    end
    if (cmd.node_rd) begin
      key_q  <= key_mem[cur[IDX_W-1:0]];
      val_q  <= val_mem[cur[IDX_W-1:0]];
      next_q <= next_mem[cur[IDX_W-1:0]];
    end
    if (cmd.node_cmp) begin
      if (key_q == key_r) begin
        found <= 1'b1;
      end else begin
        prev  <= cur;
        cur   <= next_q;
        steps <= steps + PTR_W'(1);
      end
    end
    if (cmd.apply) begin
      res_status <= ST_OK;
      res_vout   <= '0;
      if (func_r == FN_ADD) begin
        if (found) begin
          val_mem[cur[IDX_W-1:0]] <= val_r;
        end else if (full_q) begin
          res_status <= ST_FULL;
        end else begin
          key_mem[fr_q]  <= key_r;
          val_mem[fr_q]  <= val_r;
          next_mem[fr_q] <= NIL;
          if (prev[IDX_W]) head_mem[rem] <= fr_q;
        end
      end else if (!found) begin
        res_status <= ST_MISS;
      end else if (func_r == FN_REMOVE) begin
        if (prev[IDX_W]) head_mem[rem] <= next_q[IDX_W-1:0];
        else next_mem[prev[IDX_W-1:0]] <= next_q;
      end else begin
        if (change_wr) begin
          val_mem[cur[IDX_W-1:0]] <= val_r;
          res_vout <= val_r;
        end else begin
          res_vout <= val_q;
        end
      end
    end
    if (cmd.link) next_mem[prev[IDX_W-1:0]] <= {1'b0, fr_q};
    if (cmd.emit) begin
      rsp.status      <= res_status;
      rsp.entry_count <= count;
      rsp.value_out   <= res_vout;
    end
  end

endmodule

// ----- rtl/chained_hash_map_engine.sv -----
// top level of the chained hash map engine
//
//   channel | signals                     | word
//   req     | req_valid, req_ready, req   | func, key, value_in
//   rsp     | rsp_valid, rsp_ready, rsp   | status, entry_count, value_out
//   cfg     | cfg_we, cfg_data            | bucket_count
//
// one request at a time; the modulo of the 64-bit hash works 4 bits per cycle, each chain node
// costs a memory read and a compare, and an add behind a chain tail passes an extra link state;
// the engine returns to idle as the result word is registered
// rst is synchronous; a word waiting on rsp stalls the next request only in its done state
module chained_hash_map_engine import chm_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_ready,
  input  req_t             req,
  output logic             rsp_valid,
  input  logic             rsp_ready,
  output rsp_t             rsp,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_data
);

  cmd_t cmd;
  sts_t sts;

  chm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  chm_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .req       (req),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule

// ----- rtl/chm_checker.sv -----
// port-level checks for the chained hash map engine, bound to the top level
module chm_checker import chm_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             req_valid,
  input logic             req_ready,
  input req_t             req,
  input logic             rsp_valid,
  input logic             rsp_ready,
  input rsp_t             rsp
);

  // one request in flight: engine is busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("req_ready high right after accept");

  a_req_hold: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_ready |=> req_valid && $stable(req))
    else $error("waiting request word dropped or changed");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp.entry_count <= CNT_W'(POOL_ENTRIES))
    else $error("entry count above pool size");

  a_value_zero_on_fail: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status != ST_OK |-> rsp.value_out == '0)
    else $error("nonzero value on failed request");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("stalled word dropped or changed");

endmodule

bind chained_hash_map_engine chm_checker u_chm_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_ready (req_ready),
  .req       (req),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp       (rsp)
);

// ----- verif/tb_chained_hash_map_engine.sv -----
// self-checking testbench for the chained hash map engine
module tb_chained_hash_map_engine;
  import chm_pkg::*;

  class map_scoreboard;
    int unsigned bucket_count;
    int unsigned head[NUM_BUCKETS];
    logic [63:0] node_key[POOL_ENTRIES];
    logic [63:0] node_val[POOL_ENTRIES];
    int unsigned node_next[POOL_ENTRIES];
    bit          in_use[POOL_ENTRIES];
    int unsigned entries;
    rsp_t        pending[$];
    int          errors;
    int          n_checked;
    int          n_full;
    int          n_miss;

    function new();
      bucket_count = 64;
      entries = 0;
      errors = 0;
      n_checked = 0;
      n_full = 0;
      n_miss = 0;
      foreach (head[i]) head[i] = POOL_ENTRIES;
      foreach (in_use[i]) begin
        in_use[i] = 0;
        node_next[i] = POOL_ENTRIES;
        node_key[i] = '0;
        node_val[i] = '0;
      end
    endfunction

    function void set_buckets(logic [CFG_W-1:0] v);
      bucket_count = v;
    endfunction

    function int unsigned bucket_of(logic [63:0] k);
      logic [63:0] prod;
      logic [63:0] m;
      m = bucket_count;
      if (m == 0) m = 1;
      if (m > NUM_BUCKETS) m = NUM_BUCKETS;
      prod = k * 64'd62342347;
      return int'(prod % m);
    endfunction

    // predict the result of one accepted request word
    function void note_request(req_t r);
      int unsigned b, cur, prv, last, hit, steps, fr;
      rsp_t e;
      b = bucket_of(r.key);
      cur = head[b];
      prv = POOL_ENTRIES;
      hit = POOL_ENTRIES;
      steps = 0;
      while (cur < POOL_ENTRIES && steps < POOL_ENTRIES && hit == POOL_ENTRIES) begin
        if (node_key[cur] == r.key) hit = cur;
        else begin
          prv = cur;
          cur = node_next[cur];
          steps++;
        end
      end
      last = (hit < POOL_ENTRIES) ? hit : prv;
      e.status = ST_OK;
      e.value_out = '0;
      case (r.func)
        FN_ADD: begin
          if (hit < POOL_ENTRIES) node_val[hit] = r.value_in;
          else begin
            fr = POOL_ENTRIES;
            for (int i = POOL_ENTRIES - 1; i >= 0; i--) if (!in_use[i]) fr = i;
            if (fr == POOL_ENTRIES) begin
              e.status = ST_FULL;
              n_full++;
            end else begin
              in_use[fr] = 1;
              node_key[fr] = r.key;
              node_val[fr] = r.value_in;
              node_next[fr] = POOL_ENTRIES;
              if (last < POOL_ENTRIES) node_next[last] = fr;
              else head[b] = fr;
              entries++;
            end
          end
        end
        FN_REMOVE: begin
          if (hit < POOL_ENTRIES) begin
            if (prv < POOL_ENTRIES) node_next[prv] = node_next[hit];
            else head[b] = node_next[hit];
            in_use[hit] = 0;
            node_next[hit] = POOL_ENTRIES;
            if (entries > 0) entries--;
          end else e.status = ST_MISS;
        end
        default: begin
          if (hit < POOL_ENTRIES) begin
            if (r.func == FN_CHANGE && r.value_in != ALL_ONES) node_val[hit] = r.value_in;
            e.value_out = node_val[hit];
          end else e.status = ST_MISS;
        end
      endcase
      if (e.status == ST_MISS) n_miss++;
      e.entry_count = CNT_W'(entries);
      pending.push_back(e);
    endfunction

    function void check_result(rsp_t a);
      rsp_t e;
      n_checked++;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result word %p", $realtime, a);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (a.status !== e.status) begin
        $display("%0t: status expected %0d actual %0d", $realtime, e.status, a.status);
        errors++;
      end
      if (a.entry_count !== e.entry_count) begin
        $display("%0t: entry_count expected %0d actual %0d", $realtime, e.entry_count,
                 a.entry_count);
        errors++;
      end
      if (a.value_out !== e.value_out) begin
        $display("%0t: value_out expected %h actual %h", $realtime, e.value_out, a.value_out);
        errors++;
      end
    endfunction
  endclass

  logic             clk;
  logic             rst;
  logic             req_valid;
  logic             req_ready;
  req_t             req;
  logic             rsp_valid;
  logic             rsp_ready;
  rsp_t             rsp;
  logic             cfg_we;
  logic [CFG_W-1:0] cfg_data;

  map_scoreboard sb;
  logic [63:0]   key_pool[96];
  bit            hold_off;
  bit            quiet;
  int            n_sent;

  chained_hash_map_engine u_dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  initial begin
    #8000000;
    $display("FAIL");
    $finish;
  end

  // mostly short gaps, a few long ones, none in quiet stretches
  function automatic int gap_len();
    int r;
    r = $urandom_range(99);
    if (quiet) return 0;
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  task automatic send_word(logic [1:0] f, logic [63:0] k, logic [63:0] v);
    int g;
    req_valid = 1;
    req.func = f;
    req.key = k;
    req.value_in = v;
    do @(posedge clk); while (!req_ready);
    sb.note_request(req);
    n_sent++;
    @(negedge clk);
    g = gap_len();
    if (g > 0) begin
      req_valid = 0;
      repeat (g) @(negedge clk);
    end
  endtask

  task automatic drain_and_write(logic [CFG_W-1:0] v);
    req_valid = 0;
    while (sb.pending.size() != 0) @(negedge clk);
    cfg_we = 1;
    cfg_data = v;
    sb.set_buckets(v);
    @(negedge clk);
    cfg_we = 0;
  endtask

  task automatic random_phase(int count, int add_pct);
    int r;
    logic [1:0]  f;
    logic [63:0] k;
    logic [63:0] v;
    for (int i = 0; i < count; i++) begin
      if (i % 60 == 0) quiet = ($urandom_range(3) == 0);
      r = $urandom_range(99);
      if (r < add_pct) f = FN_ADD;
      else f = 2'($urandom_range(3, 1));
      k = ($urandom_range(9) == 0) ? {$urandom, $urandom} : key_pool[$urandom_range(95)];
      v = ($urandom_range(9) == 0) ? ALL_ONES : {$urandom, $urandom};
      send_word(f, k, v);
    end
    quiet = 0;
  endtask

  // receiver: random stalls plus one long hold-off on request
  initial begin
    int stall;
    int held;
    rsp_ready = 0;
    held = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_off && !held) begin
        rsp_ready = 0;
        repeat (300) @(negedge clk);
        held = 1;
      end
      stall = gap_len();
      rsp_ready = (stall == 0);
      @(posedge clk);
      if (rsp_valid && rsp_ready) sb.check_result(rsp);
      @(negedge clk);
      if (stall > 0) begin
        rsp_ready = 0;
        repeat (stall - 1) @(negedge clk);
      end
    end
  end

  initial begin
    logic [CFG_W-1:0] settings[7];
    int               add_mix[7];
    sb = new();
    req_valid = 0;
    req = '0;
    cfg_we = 0;
    cfg_data = '0;
    hold_off = 0;
    quiet = 0;
    n_sent = 0;
    settings = '{7'd64, 7'd1, 7'd0, 7'd127, 7'd7, 7'd33, 7'd64};
    add_mix = '{75, 40, 55, 35, 80, 50, 40};
    foreach (key_pool[i]) key_pool[i] = {$urandom, $urandom};
    key_pool[0] = '0;
    key_pool[1] = ALL_ONES;
    rst = 1;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // directed: extreme keys and values, every operation, misses
    send_word(FN_LOOKUP, 64'd0, 64'd0);
    send_word(FN_REMOVE, ALL_ONES, 64'd0);
    send_word(FN_CHANGE, 64'd5, 64'd1);
    send_word(FN_ADD, 64'd0, 64'd0);
    send_word(FN_ADD, ALL_ONES, ALL_ONES);
    send_word(FN_ADD, ALL_ONES, ALL_ONES);   // all-ones value stored, no duplicate
    send_word(FN_LOOKUP, ALL_ONES, 64'd0);
    send_word(FN_CHANGE, ALL_ONES, ALL_ONES); // no update
    send_word(FN_CHANGE, ALL_ONES, 64'h0123456789abcdef);
    send_word(FN_ADD, 64'd0, 64'h8000000000000001);
    send_word(FN_LOOKUP, 64'd0, ALL_ONES);
    send_word(FN_REMOVE, 64'd0, 64'd0);
    send_word(FN_LOOKUP, 64'd0, 64'd0);
    send_word(FN_REMOVE, ALL_ONES, 64'd0);

    // random phases across bucket settings, the table keeps its entries between them
    for (int p = 0; p < 7; p++) begin
      drain_and_write(settings[p]);
      if (p == 0) hold_off = 1;
      random_phase(184, add_mix[p]);
    end

    req_valid = 0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (200) @(posedge clk);
    $display("sent %0d request words, checked %0d results (%0d misses, %0d full)",
             n_sent, sb.n_checked, sb.n_miss, sb.n_full);
    $display("bucket counts 64, 1, 0, 127, 7, 33 and 64 with entries kept across changes");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/chm_pkg.sv
rtl/chm_ctrl.sv
rtl/chm_dp.sv
rtl/chained_hash_map_engine.sv
rtl/chm_checker.sv
verif/tb_chained_hash_map_engine.sv
